// ===== src/ffa_pkg.sv =====
// Shared types and constants for the first-free frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

	localparam int OP_W    = 2;
	localparam int IDX_W   = 7;
	localparam int PID_W   = 15;
	localparam int PAGE_W  = 20;
	localparam int OPID_W  = 16;
	localparam int OPAGE_W = 21;
	localparam int FREE_W  = 8;
	localparam int GROUP_W = 32;
	localparam int GBIT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RESERVE = 2'd2,
		OP_INSPECT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_TAKEN   = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== src/ffa_ctrl.sv =====
// Controller state machine: sequences capture and commit of each word.
`timescale 1ns / 1ps
`default_nettype none

module ffa_ctrl
	import ffa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		in_stall    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/ffa_dp.sv =====
// Datapath: free bitmap, two-level first-free search, tag memory, counter, result register.
`timescale 1ns / 1ps
`default_nettype none

module ffa_dp
	import ffa_pkg::*;
#(
	parameter int FRAME_COUNT = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [IDX_W-1:0]     frame_sel,
	input  wire logic [PID_W-1:0]     req_pid,
	input  wire logic [PAGE_W-1:0]    req_page,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                status,
	output logic [IDX_W-1:0]          frame_number,
	output logic                      frame_taken,
	output logic signed [OPID_W-1:0]  frame_pid,
	output logic signed [OPAGE_W-1:0] frame_page,
	output logic [FREE_W-1:0]         free_total
);

	localparam int NG    = (FRAME_COUNT + GROUP_W - 1) / GROUP_W;
	localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
	localparam int AW    = $clog2(FRAME_COUNT);
	localparam int CW    = $clog2(FRAME_COUNT + 1);
	localparam int MEM_W = PID_W + OPAGE_W;

	// frame state
	logic [FRAME_COUNT-1:0] busy_q;
	logic [CW-1:0]          cnt_q;
	logic [MEM_W-1:0]       mem [FRAME_COUNT];
	logic [MEM_W-1:0]       rd_q;

	// captured word
	op_t              op_q;
	logic [IDX_W-1:0] idx_q;
	logic [PID_W-1:0] pid_q;
	logic [PAGE_W-1:0] page_q;
	logic [GW-1:0]    grp_q;
	logic             found_q;

	// result register
	logic                      out_valid_q;
	status_t                   status_q;
	logic [IDX_W-1:0]          number_q;
	logic                      taken_q;
	logic signed [OPID_W-1:0]  opid_q;
	logic signed [OPAGE_W-1:0] opage_q;
	logic [FREE_W-1:0]         free_q;

	// search
	logic [NG*GROUP_W-1:0] free_pad;
	logic [NG-1:0]         grp_any;
	logic [GW-1:0]         grp_sel;
	logic [GROUP_W-1:0]    grp_bits;
	logic [GBIT_W-1:0]     bit_sel;
	logic [GW+GBIT_W-1:0]  alloc_full;
	logic [AW-1:0]         alloc_idx;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         idx_addr_q;
	logic                  in_range;

	// commit controls
	status_t                   st_d;
	logic [IDX_W-1:0]          num_d;
	logic                      taken_d;
	logic signed [OPID_W-1:0]  opid_d;
	logic signed [OPAGE_W-1:0] opage_d;
	logic                      clr_d;
	logic                      set_d;
	logic [AW-1:0]             set_idx_d;
	logic [MEM_W-1:0]          wd_d;
	logic [CW-1:0]             cnt_d;

	always_comb begin
		free_pad = '0;
		free_pad[FRAME_COUNT-1:0] = ~busy_q;
		for (int g = 0; g < NG; g++) begin
			grp_any[g] = |free_pad[g*GROUP_W +: GROUP_W];
		end
		grp_sel = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				grp_sel = GW'(g);
			end
		end
	end

	always_comb begin
		grp_bits = free_pad[grp_q*GROUP_W +: GROUP_W];
		bit_sel  = '0;
		for (int b = GROUP_W - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				bit_sel = GBIT_W'(b);
			end
		end
		alloc_full = {grp_q, bit_sel};
		alloc_idx  = alloc_full[AW-1:0];
	end

	assign rd_addr    = AW'(frame_sel);
	assign idx_addr_q = AW'(idx_q);
	assign in_range   = (32'(idx_q) < FRAME_COUNT);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(op);
			idx_q   <= frame_sel;
			pid_q   <= req_pid;
			page_q  <= req_page;
			grp_q   <= grp_sel;
			found_q <= |grp_any;
			rd_q    <= mem[rd_addr];
		end
		if (cmd.commit && set_d && (op_q == OP_ALLOC || op_q == OP_RESERVE)) begin
			mem[set_idx_d] <= wd_d;
		end
	end

	always_comb begin
		st_d      = ST_DONE;
		num_d     = '0;
		taken_d   = 1'b0;
		opid_d    = '0;
		opage_d   = '0;
		clr_d     = 1'b0;
		set_d     = 1'b0;
		set_idx_d = alloc_idx;
		wd_d      = {pid_q, 1'b0, page_q};
		unique case (op_q)
			OP_CLEAR: begin
				clr_d = 1'b1;
			end
			OP_ALLOC: begin
				if (found_q) begin
					set_d = 1'b1;
					num_d = IDX_W'(alloc_idx);
				end else begin
					st_d = ST_NO_FREE;
				end
			end
			OP_RESERVE: begin
				num_d     = idx_q;
				set_idx_d = idx_addr_q;
				wd_d      = {{PID_W{1'b0}}, {OPAGE_W{1'b1}}};
				if (in_range && !busy_q[idx_addr_q]) begin
					set_d = 1'b1;
				end else begin
					st_d = ST_TAKEN;
				end
			end
			OP_INSPECT: begin
				num_d   = idx_q;
				opid_d  = '1;
				opage_d = '1;
				if (in_range && busy_q[idx_addr_q]) begin
					taken_d = 1'b1;
					opid_d  = {1'b0, rd_q[MEM_W-1 -: PID_W]};
					opage_d = rd_q[OPAGE_W-1:0];
				end
			end
			default: begin
				st_d = ST_DONE;
			end
		endcase
		if (clr_d) begin
			cnt_d = CW'(FRAME_COUNT);
		end else if (set_d && cnt_q != '0) begin
			cnt_d = cnt_q - 1'b1;
		end else begin
			cnt_d = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			cnt_q       <= CW'(FRAME_COUNT);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				cnt_q <= cnt_d;
				if (clr_d) begin
					busy_q <= '0;
				end else if (set_d) begin
					busy_q[set_idx_d] <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= st_d;
			number_q <= num_d;
			taken_q  <= taken_d;
			opid_q   <= opid_d;
			opage_q  <= opage_d;
			free_q   <= FREE_W'(cnt_d);
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign frame_number = number_q;
	assign frame_taken  = taken_q;
	assign frame_pid    = opid_q;
	assign frame_page   = opage_q;
	assign free_total   = free_q;

endmodule

`default_nettype wire

// ===== src/first_free_frame_allocator.sv =====
// Top level of the first-free frame allocator: controller, datapath and checks.
// An accepted word is captured, then committed to the output register once it is free.
// No new word is accepted until the last one has committed to the output register.
// Allocation searches 32-frame groups in the capture cycle and bits within a group at commit.
// Reset clears the busy bitmap and sets the free count to FRAME_COUNT at once, no sweep.
// The tag memory is not reset; free frames always read back as -1 through the bitmap.
`timescale 1ns / 1ps
`default_nettype none

module first_free_frame_allocator
	import ffa_pkg::*;
#(
	parameter int FRAME_COUNT = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [IDX_W-1:0]     frame_sel,
	input  wire logic [PID_W-1:0]     req_pid,
	input  wire logic [PAGE_W-1:0]    req_page,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                status,
	output logic [IDX_W-1:0]          frame_number,
	output logic                      frame_taken,
	output logic signed [OPID_W-1:0]  frame_pid,
	output logic signed [OPAGE_W-1:0] frame_page,
	output logic [FREE_W-1:0]         free_total
);

	cmd_t cmd;
	sts_t sts;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffa_dp #(
		.FRAME_COUNT (FRAME_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.frame_sel    (frame_sel),
		.req_pid      (req_pid),
		.req_page     (req_page),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.frame_number (frame_number),
		.frame_taken  (frame_taken),
		.frame_pid    (frame_pid),
		.frame_page   (frame_page),
		.free_total   (free_total)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.commit))
		else $error("capture and commit in the same cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("new word accepted while one is in flight");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed result not presented");

	a_no_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NO_FREE) |-> (free_total == '0))
		else $error("allocate failed with free frames left");

endmodule

`default_nettype wire

// ===== dv/first_free_frame_allocator_test.sv =====
// Self-checking testbench for the first-free frame allocator: directed table, random runs.
`timescale 1ns / 1ps

module first_free_frame_allocator_test
	import ffa_pkg::*;
;

	localparam int FRAMES      = 128;
	localparam int WORD_COUNT  = 1300;
	localparam int HOLD_CYCLES = 400;
	localparam int STUCK_LIMIT = 4000;

	typedef struct packed {
		status_t              st;
		logic [IDX_W-1:0]     num;
		logic                 taken;
		logic [OPID_W-1:0]    pid;
		logic [OPAGE_W-1:0]   page;
		logic [FREE_W-1:0]    free;
	} frame_result_t;

	typedef struct packed {
		op_t                  o;
		logic [IDX_W-1:0]     idx;
		logic [PID_W-1:0]     pid;
		logic [PAGE_W-1:0]    page;
		logic                 typed;
		frame_result_t        want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [OP_W-1:0]      op;
	logic [IDX_W-1:0]     frame_sel;
	logic [PID_W-1:0]     req_pid;
	logic [PAGE_W-1:0]    req_page;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           status;
	logic [IDX_W-1:0]     frame_number;
	logic                 frame_taken;
	logic [OPID_W-1:0]    frame_pid;
	logic [OPAGE_W-1:0]   frame_page;
	logic [FREE_W-1:0]    free_total;

	// model of the frame table
	logic                 busy_map [FRAMES];
	logic [OPID_W-1:0]    owner_tag [FRAMES];
	logic [OPAGE_W-1:0]   page_tag [FRAMES];
	int                   free_frames;

	frame_result_t        pending_results [$];
	int                   fail_count = 0;
	int                   words_sent = 0;
	int                   stuck_cycles = 0;
	bit                   quiet = 0;
	bit                   hold_long = 0;

	stim_row_t directed_rows [] = '{
		'{OP_INSPECT, 7'd0, 15'd0, 20'd0, 1'b1,
			'{ST_DONE, 7'd0, 1'b0, 16'hFFFF, 21'h1FFFFF, 8'd128}},
		'{OP_INSPECT, 7'd127, 15'd0, 20'd0, 1'b1,
			'{ST_DONE, 7'd127, 1'b0, 16'hFFFF, 21'h1FFFFF, 8'd128}},
		'{OP_ALLOC, 7'd0, 15'h7FFF, 20'hFFFFF, 1'b1,
			'{ST_DONE, 7'd0, 1'b0, 16'h0, 21'h0, 8'd127}},
		'{OP_INSPECT, 7'd0, 15'd0, 20'd0, 1'b1,
			'{ST_DONE, 7'd0, 1'b1, 16'h7FFF, 21'h0FFFFF, 8'd127}},
		'{OP_RESERVE, 7'd0, 15'd0, 20'd0, 1'b1,
			'{ST_TAKEN, 7'd0, 1'b0, 16'h0, 21'h0, 8'd127}},
		'{OP_RESERVE, 7'd127, 15'h7FFF, 20'hFFFFF, 1'b1,
			'{ST_DONE, 7'd127, 1'b0, 16'h0, 21'h0, 8'd126}},
		'{OP_INSPECT, 7'd127, 15'd0, 20'd0, 1'b1,
			'{ST_DONE, 7'd127, 1'b1, 16'h0, 21'h1FFFFF, 8'd126}},
		'{OP_ALLOC, 7'd127, 15'd0, 20'd0, 1'b1,
			'{ST_DONE, 7'd1, 1'b0, 16'h0, 21'h0, 8'd125}},
		'{OP_INSPECT, 7'd1, 15'h7FFF, 20'hFFFFF, 1'b1,
			'{ST_DONE, 7'd1, 1'b1, 16'h0, 21'h0, 8'd125}},
		'{OP_RESERVE, 7'd2, 15'h1234, 20'h12345, 1'b0, '0},
		'{OP_ALLOC, 7'd0, 15'h5555, 20'hAAAAA, 1'b0, '0},
		'{OP_INSPECT, 7'd3, 15'd0, 20'd0, 1'b0, '0},
		'{OP_ALLOC, 7'd127, 15'h2AAA, 20'h55555, 1'b0, '0},
		'{OP_INSPECT, 7'd4, 15'd0, 20'd0, 1'b0, '0},
		'{OP_INSPECT, 7'd2, 15'd0, 20'd0, 1'b0, '0},
		'{OP_RESERVE, 7'd127, 15'd0, 20'd0, 1'b0, '0},
		'{OP_CLEAR, 7'd127, 15'h7FFF, 20'hFFFFF, 1'b1,
			'{ST_DONE, 7'd0, 1'b0, 16'h0, 21'h0, 8'd128}},
		'{OP_INSPECT, 7'd127, 15'd0, 20'd0, 1'b1,
			'{ST_DONE, 7'd127, 1'b0, 16'hFFFF, 21'h1FFFFF, 8'd128}},
		'{OP_INSPECT, 7'd0, 15'd0, 20'd0, 1'b1,
			'{ST_DONE, 7'd0, 1'b0, 16'hFFFF, 21'h1FFFFF, 8'd128}},
		'{OP_CLEAR, 7'd0, 15'd0, 20'd0, 1'b1,
			'{ST_DONE, 7'd0, 1'b0, 16'h0, 21'h0, 8'd128}},
		'{OP_ALLOC, 7'd85, 15'h0F0F, 20'hF0F0F, 1'b1,
			'{ST_DONE, 7'd0, 1'b0, 16'h0, 21'h0, 8'd127}},
		'{OP_RESERVE, 7'd1, 15'd0, 20'd0, 1'b0, '0},
		'{OP_INSPECT, 7'd64, 15'd0, 20'd0, 1'b0, '0}
	};

	first_free_frame_allocator #(
		.FRAME_COUNT(FRAMES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.frame_sel(frame_sel),
		.req_pid(req_pid),
		.req_page(req_page),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.frame_number(frame_number),
		.frame_taken(frame_taken),
		.frame_pid(frame_pid),
		.frame_page(frame_page),
		.free_total(free_total)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic frame_result_t frame_table_step(op_t o, logic [IDX_W-1:0] idx,
			logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page);
		frame_result_t r;
		int first;
		r = '0;
		r.st = ST_DONE;
		first = -1;
		case (o)
			OP_CLEAR: begin
				for (int i = 0; i < FRAMES; i++) begin
					busy_map[i] = 1'b0;
					owner_tag[i] = '1;
					page_tag[i] = '1;
				end
				free_frames = FRAMES;
			end
			OP_ALLOC: begin
				for (int i = FRAMES - 1; i >= 0; i--)
					if (!busy_map[i])
						first = i;
				if (first < 0) begin
					r.st = ST_NO_FREE;
				end else begin
					busy_map[first] = 1'b1;
					owner_tag[first] = {1'b0, pid};
					page_tag[first] = {1'b0, page};
					free_frames--;
					r.num = first[IDX_W-1:0];
				end
			end
			OP_RESERVE: begin
				r.num = idx;
				if (!busy_map[idx]) begin
					busy_map[idx] = 1'b1;
					owner_tag[idx] = '0;
					page_tag[idx] = '1;
					free_frames--;
				end else begin
					r.st = ST_TAKEN;
				end
			end
			default: begin
				r.num = idx;
				r.taken = busy_map[idx];
				r.pid = owner_tag[idx];
				r.page = page_tag[idx];
			end
		endcase
		r.free = free_frames[FREE_W-1:0];
		return r;
	endfunction

	task automatic send_word(op_t o, logic [IDX_W-1:0] idx, logic [PID_W-1:0] pid,
			logic [PAGE_W-1:0] page, logic typed, frame_result_t want);
		frame_result_t r;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		frame_sel <= idx;
		req_pid <= pid;
		req_page <= page;
		do
			@(posedge clk);
		while (in_stall);
		r = frame_table_step(o, idx, pid, page);
		pending_results.push_back(typed ? want : r);
		words_sent++;
		if (words_sent == 300)
			hold_long = 1'b1;
		if (words_sent >= WORD_COUNT - 200)
			quiet = 1'b1;
	endtask

	task automatic send_random(op_t o);
		send_word(o, IDX_W'($urandom_range(0, FRAMES - 1)), PID_W'($urandom),
			PAGE_W'($urandom), 1'b0, '0);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// receiver side
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_long = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing pending");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.st), 32'(status));
				check_field("frame_number", 32'(want.num), 32'(frame_number));
				check_field("frame_taken", 32'(want.taken), 32'(frame_taken));
				check_field("frame_pid", 32'(want.pid), 32'(frame_pid));
				check_field("frame_page", 32'(want.page), 32'(frame_page));
				check_field("free_total", 32'(want.free), 32'(free_total));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		bit paused;
		int pick;
		paused = 1'b0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		op <= OP_CLEAR;
		frame_sel <= '0;
		req_pid <= '0;
		req_page <= '0;
		void'(frame_table_step(OP_CLEAR, '0, '0, '0));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].o, directed_rows[i].idx, directed_rows[i].pid,
				directed_rows[i].page, directed_rows[i].typed, directed_rows[i].want);

		while (words_sent < WORD_COUNT) begin
			if (!paused && words_sent >= 700) begin
				paused = 1'b1;
				drain_results();
			end
			if ($urandom_range(0, 3) == 0) begin
				// fill the table, push past full, then mostly clear
				while (free_frames > 0 && words_sent < WORD_COUNT) begin
					pick = $urandom_range(0, 9);
					if (pick < 6)
						send_random(OP_ALLOC);
					else if (pick < 8)
						send_random(OP_RESERVE);
					else
						send_random(OP_INSPECT);
				end
				repeat ($urandom_range(2, 6)) begin
					send_random(OP_ALLOC);
					send_random($urandom_range(0, 1) ? OP_RESERVE : OP_INSPECT);
				end
				if ($urandom_range(0, 3) != 0)
					send_random(OP_CLEAR);
			end else begin
				repeat ($urandom_range(10, 40)) begin
					pick = $urandom_range(0, 99);
					if (pick < 3)
						send_random(OP_CLEAR);
					else if (pick < 45)
						send_random(OP_ALLOC);
					else if (pick < 70)
						send_random(OP_RESERVE);
					else
						send_random(OP_INSPECT);
				end
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== first_free_frame_allocator.f =====
src/ffa_pkg.sv
src/ffa_ctrl.sv
src/ffa_dp.sv
src/first_free_frame_allocator.sv
dv/first_free_frame_allocator_test.sv
